>>> hdl/wats_pkg.sv
// shared types, constants and codes for the weekly alarm table scanner
`timescale 1ns / 1ps
package wats_pkg;

  localparam int SLOTS = 32;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W = 6;
  localparam int CNT_W = 6;
  localparam int NOW_W = 17;
  localparam int DUE_W = 18;
  localparam int DIFF_W = 19;

  localparam logic [7:0] DELETE_HOUR = 8'hFF;
  localparam logic [7:0] MAX_HOUR = 8'd23;
  localparam logic [7:0] MAX_MIN_SEC = 8'd59;
  localparam logic [NOW_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [NOW_W-1:0] SECS_PER_MIN = 17'd60;
  localparam logic [DUE_W-1:0] DAY_SECS = 18'd86400;
  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
  localparam logic signed [DIFF_W-1:0] FIRE_LOW = -19'sd2;
  localparam logic signed [DIFF_W-1:0] FIRE_HIGH = 19'sd1;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] slot_index;
    logic       alarm_enable;
    logic [6:0] weekday_mask;
    logic [7:0] alarm_hour;
    logic [7:0] alarm_minute;
    logic [7:0] alarm_second;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       clock_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [ID_W-1:0]  slot_id;
    logic [DUE_W-1:0] next_due_seconds;
    logic             next_due_valid;
    logic [CNT_W-1:0] active_count;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic       enable;
    logic [6:0] mask;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic             fire;
    logic             later;
    logic [DUE_W-1:0] secs;
  } due_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_FIND,
    S_WRITE,
    S_ACK,
    S_SCAN,
    S_SUM
  } state_t;

endpackage

>>> hdl/wats_table.sv
// alarm slot storage with per-slot valid flags and occupied count
`timescale 1ns / 1ps
module wats_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [wats_pkg::IDX_W-1:0] wr_idx,
  input  wats_pkg::entry_t         wr_entry,
  input  logic [wats_pkg::IDX_W-1:0] rd_idx,
  output wats_pkg::entry_t         rd_entry,
  output logic [wats_pkg::CNT_W-1:0] count
);
  import wats_pkg::*;

  entry_t           mem_r [SLOTS];
  entry_t           rd_data_r;
  logic             rd_valid_r;
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (wr_en) begin
      valid_nxt[wr_idx] = wr_entry.valid;
      if (wr_entry.valid && !valid_r[wr_idx]) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (!wr_entry.valid && valid_r[wr_idx]) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  // rd_idx is the slot wanted in the next cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_entry;
    end
    rd_data_r <= mem_r[rd_idx];
    rd_valid_r <= valid_r[rd_idx];
  end

  always_comb begin
    rd_entry = rd_data_r;
    rd_entry.valid = rd_valid_r;
  end

  assign count = count_r;

endmodule

>>> hdl/wats_due_unit.sv
// shared time unit: seconds from now to one alarm and its fire window
`timescale 1ns / 1ps
module wats_due_unit (
  input  wats_pkg::entry_t         entry,
  input  logic [2:0]               weekday,
  input  logic [wats_pkg::NOW_W-1:0] now_secs,
  output wats_pkg::due_t           due
);
  import wats_pkg::*;

  logic [7:0]              mask8;
  logic [3:0]              tw_sum;
  logic [2:0]              tw;
  logic                    today;
  logic                    tomorrow;
  logic [NOW_W-1:0]        at_day;
  logic [DUE_W-1:0]        at_full;
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    mask8 = {1'b0, entry.mask};
    tw_sum = {1'b0, weekday} + 4'd1;
    if (tw_sum >= {1'b0, DAYS_PER_WEEK}) begin
      tw = 3'(tw_sum - {1'b0, DAYS_PER_WEEK});
    end else begin
      tw = tw_sum[2:0];
    end
    today = mask8[weekday];
    tomorrow = mask8[tw];
    at_day = NOW_W'(entry.hour) * SECS_PER_HOUR + NOW_W'(entry.minute) * SECS_PER_MIN
           + NOW_W'(entry.second);
    at_full = today ? {1'b0, at_day} : ({1'b0, at_day} + DAY_SECS);
    diff = $signed({1'b0, at_full}) - $signed({2'b00, now_secs});
    due.hit = entry.valid && entry.enable && (today || tomorrow);
    due.fire = (diff >= FIRE_LOW) && (diff <= FIRE_HIGH);
    due.later = diff > FIRE_HIGH;
    due.secs = diff[DUE_W-1:0];
  end

endmodule

>>> hdl/weekly_alarm_table_scanner_top.sv
// Weekly alarm table scanner. A set command (start with cmd 0) writes, deletes
// or allocates one slot and gives one acknowledge result; busy stays high from
// S_SET through S_WRITE to S_ACK with an explicit slot, and when slot_index is 0
// S_FIND walks the slots in order to the first free one (or on to S_ACK when the
// table is full). A set with rejected fields or slot index goes from S_SET to
// S_ACK. A tick with a valid clock walks the table one slot per cycle through
// the single due-time unit with busy high; firing results come out in slot
// order and a next-due summary closes the tick. A tick with clock_valid low is
// taken and gives no result. Each result is shown on out_data for one cycle
// under out_valid, in the cycle after it is formed; the receiver has to take it
// then. Table state is cleared by reset (all slots free, count zero).
`timescale 1ns / 1ps
module weekly_alarm_table_scanner_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  wats_pkg::in_item_t  in_data,
  output logic                busy,
  output logic                out_valid,
  output wats_pkg::out_item_t out_data
);
  import wats_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  in_item_t         in_r;
  in_item_t         in_nxt;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] ptr_nxt;
  logic [ID_W-1:0]  id_r;
  logic [ID_W-1:0]  id_nxt;
  logic [NOW_W-1:0] now_r;
  logic [NOW_W-1:0] now_nxt;
  logic [DUE_W-1:0] next_r;
  logic [DUE_W-1:0] next_nxt;
  logic             have_r;
  logic             have_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_r;
  out_item_t        out_nxt;

  logic             accept;
  logic             set_ok;
  logic             ptr_last;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic [CNT_W-1:0] count;
  due_t             due;

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign ptr_last = (ptr_r == IDX_W'(SLOTS - 1));

  assign set_ok = !((in_r.alarm_hour > MAX_HOUR && in_r.alarm_hour != DELETE_HOUR)
                    || in_r.alarm_minute > MAX_MIN_SEC || in_r.alarm_second > MAX_MIN_SEC)
                  && (in_r.slot_index <= 8'(SLOTS));

  wats_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_idx   (ptr_nxt),
    .rd_entry (rd_entry),
    .count    (count)
  );

  wats_due_unit u_due (
    .entry    (rd_entry),
    .weekday  (in_r.now_weekday),
    .now_secs (now_r),
    .due      (due)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_SET) begin
            state_nxt = S_SET;
          end else if (in_data.clock_valid) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SET: begin
        if (!set_ok) begin
          state_nxt = S_ACK;
        end else if (in_r.slot_index == 8'd0) begin
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_FIND: begin
        if (!rd_entry.valid) begin
          state_nxt = S_WRITE;
        end else if (ptr_last) begin
          state_nxt = S_ACK;
        end
      end
      S_WRITE: state_nxt = S_ACK;
      S_ACK:   state_nxt = S_IDLE;
      S_SCAN: begin
        if (ptr_last) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    in_nxt = in_r;
    ptr_nxt = ptr_r;
    id_nxt = id_r;
    now_nxt = now_r;
    next_nxt = next_r;
    have_nxt = have_r;
    out_valid_nxt = 1'b0;
    out_nxt = '0;
    out_nxt.active_count = count;
    wr_en = 1'b0;
    wr_idx = IDX_W'(id_r - ID_W'(1));
    wr_entry.valid = (in_r.alarm_hour != DELETE_HOUR);
    wr_entry.enable = in_r.alarm_enable;
    wr_entry.mask = in_r.weekday_mask;
    wr_entry.hour = in_r.alarm_hour[4:0];
    wr_entry.minute = in_r.alarm_minute[5:0];
    wr_entry.second = in_r.alarm_second[5:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_nxt = in_data;
          ptr_nxt = '0;
          have_nxt = 1'b0;
          next_nxt = '0;
          now_nxt = NOW_W'(in_data.now_hour) * SECS_PER_HOUR
                  + NOW_W'(in_data.now_minute) * SECS_PER_MIN + NOW_W'(in_data.now_second);
        end
      end
      S_SET: begin
        ptr_nxt = '0;
        id_nxt = set_ok ? ID_W'(in_r.slot_index) : '0;
      end
      S_FIND: begin
        if (!rd_entry.valid) begin
          id_nxt = ID_W'(ptr_r) + ID_W'(1);
        end else begin
          id_nxt = '0;
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      S_WRITE: begin
        wr_en = 1'b1;
      end
      S_ACK: begin
        out_valid_nxt = 1'b1;
        out_nxt.result_kind = KIND_ACK;
        out_nxt.slot_id = id_r;
        out_nxt.last = 1'b1;
      end
      S_SCAN: begin
        ptr_nxt = ptr_r + IDX_W'(1);
        if (due.hit && due.fire) begin
          out_valid_nxt = 1'b1;
          out_nxt.result_kind = KIND_FIRE;
          out_nxt.slot_id = ID_W'(ptr_r) + ID_W'(1);
        end
        if (due.hit && due.later && (!have_r || due.secs < next_r)) begin
          next_nxt = due.secs;
          have_nxt = 1'b1;
        end
      end
      S_SUM: begin
        out_valid_nxt = 1'b1;
        out_nxt.result_kind = KIND_SUMMARY;
        out_nxt.next_due_seconds = next_r;
        out_nxt.next_due_valid = have_r;
        out_nxt.last = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    ptr_r <= ptr_nxt;
    id_r <= id_nxt;
    now_r <= now_nxt;
    next_r <= next_nxt;
    have_r <= have_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_fire_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_FIRE) |-> busy)
    else $error("fire transfer seen after the tick scan ended");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !out_valid)
    else $error("transfer directly after a final result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.active_count <= CNT_W'(SLOTS)))
    else $error("active count above the number of slots");

endmodule
